>>> rtl/core/cnsl_pkg.sv
// Shared types and constants for the chunked nearest-site lookup.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package cnsl_pkg;

	localparam int CHUNK_SIDE      = 32;
	localparam int CHUNKS_ACROSS   = 16;
	localparam int CHUNKS_DOWN     = 16;
	localparam int SITES_PER_CHUNK = 64;

	localparam int POS_W    = 9;
	localparam int COLOR_W  = 8;
	localparam int STATUS_W = 2;
	localparam int MODE_W   = 2;

	localparam int NUM_CHUNKS  = CHUNKS_ACROSS * CHUNKS_DOWN;
	localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
	localparam int SITE_IDX_W  = $clog2(SITES_PER_CHUNK);
	localparam int FILL_W      = $clog2(SITES_PER_CHUNK + 1);
	localparam int STORE_DEPTH = NUM_CHUNKS * SITES_PER_CHUNK;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int SIDE_SH     = $clog2(CHUNK_SIDE);
	localparam int CC_W        = POS_W - SIDE_SH;
	localparam int NB_W        = CC_W + 2;
	localparam int TERM_W      = 2 * POS_W;
	localparam int DIST_W      = TERM_W + 1;

	localparam logic [1:0] NB_LAST = 2'd2;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DROP  = 2'd2;

	localparam logic [MODE_W-1:0] MODE_MANHATTAN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESET     = 2'd2;

	localparam int APB_AW = 3;
	localparam logic [APB_AW-1:0] REG_DISTANCE_MODE = 3'd0;

	typedef struct packed {
		logic [COLOR_W-1:0] b;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] r;
	} color_t;

	typedef struct packed {
		color_t           color;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] x;
	} site_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_Q_RD,
		ST_Q_CHK,
		ST_Q_WALK,
		ST_Q_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic fill_rd;
		logic add_wr;
		logic nb_step;
		logic set_empty;
		logic walk_start;
		logic walk_issue;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic nb_in_grid;
		logic nb_last;
		logic q_in_grid;
		logic fill_zero;
		logic walk_last;
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/core/cnsl_ctrl.sv
// Controller state machine for the chunked nearest-site lookup.
// Depends on cnsl_pkg; drives the datapath through cmd_t and watches sts_t.
`default_nettype none
module cnsl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	input  wire logic           in_func,
	output logic                s_tready,
	output cnsl_pkg::cmd_t      cmd,
	input  wire cnsl_pkg::sts_t sts
);
	import cnsl_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   accept;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = (in_func == FUNC_ADD) ? ST_ADD_RD : ST_Q_RD;
				end
			end
			ST_ADD_RD: begin
				if (sts.nb_in_grid) begin
					state_nx = ST_ADD_WR;
				end else if (sts.nb_last) begin
					state_nx = ST_DONE;
				end
			end
			ST_ADD_WR: begin
				state_nx = sts.nb_last ? ST_DONE : ST_ADD_RD;
			end
			ST_Q_RD: begin
				state_nx = sts.q_in_grid ? ST_Q_CHK : ST_DONE;
			end
			ST_Q_CHK: begin
				state_nx = sts.fill_zero ? ST_DONE : ST_Q_WALK;
			end
			ST_Q_WALK: begin
				if (sts.walk_last) begin
					state_nx = ST_Q_DRAIN;
				end
			end
			ST_Q_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = accept;
			end
			ST_ADD_RD: begin
				cmd.fill_rd = sts.nb_in_grid;
				cmd.nb_step = !sts.nb_in_grid && !sts.nb_last;
			end
			ST_ADD_WR: begin
				cmd.add_wr  = 1'b1;
				cmd.nb_step = !sts.nb_last;
			end
			ST_Q_RD: begin
				cmd.fill_rd   = sts.q_in_grid;
				cmd.set_empty = !sts.q_in_grid;
			end
			ST_Q_CHK: begin
				cmd.set_empty  = sts.fill_zero;
				cmd.walk_start = !sts.fill_zero;
			end
			ST_Q_WALK: begin
				cmd.walk_issue = 1'b1;
			end
			ST_Q_DRAIN: begin
			end
			ST_DONE: begin
				cmd.emit = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/cnsl_datapath.sv
// Datapath of the chunked nearest-site lookup: item register, chunk fill
// counts, site store, distance pipeline, best-site tracker and output register.
// Depends on cnsl_pkg; commanded by cnsl_ctrl.
`default_nettype none
module cnsl_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_func,
	input  wire cnsl_pkg::site_t               in_site,
	input  wire logic [cnsl_pkg::MODE_W-1:0]   distance_mode,
	input  wire cnsl_pkg::cmd_t                cmd,
	output cnsl_pkg::sts_t                     sts,
	input  wire logic                          m_tready,
	output logic                               m_tvalid,
	output cnsl_pkg::color_t                   out_color,
	output logic [cnsl_pkg::STATUS_W-1:0]      out_status
);
	import cnsl_pkg::*;

	// Item register
	logic  item_func_q;
	site_t item_q;
	logic  drop_q;
	logic  empty_q;
	logic  fill_full;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_func_q <= in_func;
			item_q      <= in_site;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q  <= 1'b0;
			empty_q <= 1'b0;
		end else if (cmd.load) begin
			drop_q  <= 1'b0;
			empty_q <= 1'b0;
		end else begin
			if (cmd.add_wr && fill_full) begin
				drop_q <= 1'b1;
			end
			if (cmd.set_empty) begin
				empty_q <= 1'b1;
			end
		end
	end

	// Chunk coordinates of the item and of the current neighbor
	logic [CC_W-1:0]        cx;
	logic [CC_W-1:0]        cy;
	logic [1:0]             nb_dx_q;
	logic [1:0]             nb_dy_q;
	logic signed [NB_W-1:0] nx;
	logic signed [NB_W-1:0] ny;
	logic [CHUNK_IDX_W-1:0] nb_idx;
	logic [CHUNK_IDX_W-1:0] q_idx;

	assign cx = CC_W'(item_q.x >> SIDE_SH);
	assign cy = CC_W'(item_q.y >> SIDE_SH);
	assign nx = $signed({2'b00, cx}) + $signed({{(NB_W-2){1'b0}}, nb_dx_q}) - NB_W'(1);
	assign ny = $signed({2'b00, cy}) + $signed({{(NB_W-2){1'b0}}, nb_dy_q}) - NB_W'(1);
	assign nb_idx = CHUNK_IDX_W'(int'(ny) * CHUNKS_ACROSS + int'(nx));
	assign q_idx  = CHUNK_IDX_W'(int'(cy) * CHUNKS_ACROSS + int'(cx));

	assign sts.nb_in_grid = (nx >= 0) && (ny >= 0) &&
		(int'(nx) < CHUNKS_ACROSS) && (int'(ny) < CHUNKS_DOWN);
	assign sts.nb_last    = (nb_dx_q == NB_LAST) && (nb_dy_q == NB_LAST);
	assign sts.q_in_grid  = (int'(cx) < CHUNKS_ACROSS) && (int'(cy) < CHUNKS_DOWN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_dx_q <= 2'd0;
			nb_dy_q <= 2'd0;
		end else if (cmd.load) begin
			nb_dx_q <= 2'd0;
			nb_dy_q <= 2'd0;
		end else if (cmd.nb_step) begin
			if (nb_dx_q == NB_LAST) begin
				nb_dx_q <= 2'd0;
				nb_dy_q <= nb_dy_q + 2'd1;
			end else begin
				nb_dx_q <= nb_dx_q + 2'd1;
			end
		end
	end

	// Fill counts: a memory plus one valid bit per chunk, so that reset
	// clears every count at once.
	logic [FILL_W-1:0]      fill_mem [NUM_CHUNKS];
	logic [NUM_CHUNKS-1:0]  fill_vld_q;
	logic [FILL_W-1:0]      fill_rdata_q;
	logic                   fill_hit_q;
	logic [CHUNK_IDX_W-1:0] fill_raddr;
	logic [FILL_W-1:0]      fill_eff;
	logic                   store_we;

	assign fill_raddr = (item_func_q == FUNC_ADD) ? nb_idx : q_idx;
	assign fill_eff   = fill_hit_q ? fill_rdata_q : '0;
	assign fill_full  = (fill_eff >= FILL_W'(SITES_PER_CHUNK));
	assign store_we   = cmd.add_wr && !fill_full;
	assign sts.fill_zero = (fill_eff == '0);

	always_ff @(posedge clk) begin
		if (cmd.fill_rd) begin
			fill_rdata_q <= fill_mem[fill_raddr];
			fill_hit_q   <= fill_vld_q[fill_raddr];
		end
		if (store_we) begin
			fill_mem[nb_idx] <= fill_eff + FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q <= '0;
		end else if (store_we) begin
			fill_vld_q[nb_idx] <= 1'b1;
		end
	end

	// Site store
	site_t               store_mem [STORE_DEPTH];
	logic [STORE_AW-1:0] store_waddr;
	logic [STORE_AW-1:0] store_raddr;
	logic [FILL_W-1:0]   walk_i_q;
	logic [FILL_W-1:0]   walk_n_q;
	site_t               rd_site_s1;

	assign store_waddr = STORE_AW'(int'(nb_idx) * SITES_PER_CHUNK +
		int'(fill_eff[SITE_IDX_W-1:0]));
	assign store_raddr = STORE_AW'(int'(q_idx) * SITES_PER_CHUNK +
		int'(walk_i_q[SITE_IDX_W-1:0]));
	assign sts.walk_last = (walk_i_q == walk_n_q - FILL_W'(1));

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_waddr] <= item_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_issue) begin
			rd_site_s1 <= store_mem[store_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_i_q <= '0;
		end else if (cmd.walk_start) begin
			walk_i_q <= '0;
		end else if (cmd.walk_issue) begin
			walk_i_q <= walk_i_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			walk_n_q <= fill_eff;
		end
	end

	// Distance pipeline: stage 1 holds the read site, stage 2 the two
	// distance terms; the sum is compared against the best so far.
	logic              v_s1;
	logic              first_s1;
	logic              v_s2;
	logic              first_s2;
	logic [POS_W-1:0]  dx;
	logic [POS_W-1:0]  dy;
	logic [TERM_W-1:0] term_x;
	logic [TERM_W-1:0] term_y;
	logic [TERM_W-1:0] term_x_s2;
	logic [TERM_W-1:0] term_y_s2;
	color_t            color_s2;
	logic [DIST_W-1:0] dist_sum;
	logic [DIST_W-1:0] best_d_q;
	color_t            best_color_q;

	assign dx = (item_q.x >= rd_site_s1.x) ? item_q.x - rd_site_s1.x :
		rd_site_s1.x - item_q.x;
	assign dy = (item_q.y >= rd_site_s1.y) ? item_q.y - rd_site_s1.y :
		rd_site_s1.y - item_q.y;

	always_comb begin
		if (distance_mode == MODE_MANHATTAN) begin
			term_x = TERM_W'(dx);
			term_y = TERM_W'(dy);
		end else begin
			term_x = TERM_W'(dx) * TERM_W'(dx);
			term_y = TERM_W'(dy) * TERM_W'(dy);
		end
	end

	assign dist_sum = DIST_W'(term_x_s2) + DIST_W'(term_y_s2);
	assign sts.pipe_busy = v_s1 || v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.walk_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_issue) begin
			first_s1 <= (walk_i_q == '0);
		end
		if (v_s1) begin
			first_s2  <= first_s1;
			term_x_s2 <= term_x;
			term_y_s2 <= term_y;
			color_s2  <= rd_site_s1.color;
		end
		// Strict less-than keeps the earliest listed site on a tie.
		if (v_s2 && (first_s2 || dist_sum < best_d_q)) begin
			best_d_q     <= dist_sum;
			best_color_q <= color_s2;
		end
	end

	// Output register
	logic                out_valid_q;
	color_t              out_color_q;
	logic [STATUS_W-1:0] out_status_q;

	assign sts.out_free = !out_valid_q || m_tready;
	assign m_tvalid     = out_valid_q;
	assign out_color    = out_color_q;
	assign out_status   = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (item_func_q == FUNC_ADD) begin
				out_color_q  <= '0;
				out_status_q <= drop_q ? STATUS_DROP : STATUS_OK;
			end else if (empty_q) begin
				out_color_q  <= '0;
				out_status_q <= STATUS_EMPTY;
			end else begin
				out_color_q  <= best_color_q;
				out_status_q <= STATUS_OK;
			end
		end
	end

`ifndef SYNTH
	a_store_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		store_we |-> (fill_eff < FILL_W'(SITES_PER_CHUNK)))
		else $error("site written into a full chunk list");

	a_walk_only_for_query: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> (item_func_q == FUNC_QUERY))
		else $error("distance pipeline active during an add");

	a_emit_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!v_s1 && !v_s2 && !cmd.walk_issue))
		else $error("result emitted before the list walk drained");
`endif

endmodule
`default_nettype wire

>>> rtl/core/chunked_nearest_site_lookup.sv
// A query reads the fill n of its chunk (at most 64), walks its n sites through the distance
// pipeline, drains it and registers the result; an empty chunk skips the walk. An add visits
// the nine neighbor chunks, reading the fill of each in-grid one and storing the site there.
// One item is in work at a time; the next is taken after the result is registered, even while
// the result waits for the receiver.
// Reset clears all fill counts through per-chunk valid bits and sets squared Euclidean mode.
`default_nettype none
module chunked_nearest_site_lookup (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// APB configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cnsl_pkg::APB_AW-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// Input items
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [47:0]                   s_tdata, // pos_x, pos_y, site_red, site_green, site_blue
	input  wire logic                          s_tuser, // func
	// Result items
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [23:0]                        m_tdata, // out_red, out_green, out_blue
	output logic [1:0]                         m_tuser  // status
);
	import cnsl_pkg::*;

	logic [MODE_W-1:0] distance_mode_q;
	logic              cfg_wr;
	cmd_t              cmd;
	sts_t              sts;
	site_t             in_site;
	color_t            out_color;
	logic [STATUS_W-1:0] out_status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_mode_q <= MODE_RESET;
		end else if (cfg_wr && paddr == REG_DISTANCE_MODE) begin
			distance_mode_q <= pwdata[MODE_W-1:0];
		end
	end

	assign prdata = (paddr == REG_DISTANCE_MODE) ? {{(32-MODE_W){1'b0}}, distance_mode_q} : '0;

	assign in_site.x       = s_tdata[8:0];
	assign in_site.y       = s_tdata[17:9];
	assign in_site.color.r = s_tdata[25:18];
	assign in_site.color.g = s_tdata[33:26];
	assign in_site.color.b = s_tdata[41:34];

	assign m_tdata = {out_color.b, out_color.g, out_color.r};
	assign m_tuser = out_status;

	cnsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_func  (s_tuser),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	cnsl_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_func       (s_tuser),
		.in_site       (in_site),
		.distance_mode (distance_mode_q),
		.cmd           (cmd),
		.sts           (sts),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.out_color     (out_color),
		.out_status    (out_status)
	);

endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking bench for chunked_nearest_site_lookup: streams add-site and query items,
// predicts every result in step with acceptance and checks the result stream in order.
// Depends on cnsl_pkg and the chunked_nearest_site_lookup RTL.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cnsl_pkg::*;

	localparam logic [APB_AW-1:0] REG_UNMAPPED   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 2'd3;
	localparam int                MAX_REPORTS    = 10;

	typedef struct packed {
		logic             func;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		color_t           color;
	} lookup_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0]  r;
		logic [COLOR_W-1:0]  g;
		logic [COLOR_W-1:0]  b;
		logic [STATUS_W-1:0] status;
	} pixel_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [47:0]         s_tdata = '0;  // pos_x, pos_y, site_red, site_green, site_blue
	logic                s_tuser = 1'b0; // func
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [23:0]         m_tdata;       // out_red, out_green, out_blue
	logic [1:0]          m_tuser;       // status

	chunked_nearest_site_lookup DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// Predictor state: a private copy of the chunk lists and the distance mode.
	site_t              site_list [NUM_CHUNKS][SITES_PER_CHUNK];
	logic [FILL_W-1:0]  fill_count [NUM_CHUNKS];
	logic [MODE_W-1:0]  dist_mode = MODE_RESET;

	lookup_item_t       item_backlog [$];
	pixel_result_t      expected_pixels [$];
	int                 mismatches = 0;
	bit                 calm = 1'b0;
	bit                 s_fire = 1'b0;
	int unsigned        send_gap = 0;
	int unsigned        stall_left = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Applies one item to the private chunk lists and returns the pixel it should produce.
	function automatic pixel_result_t predict_lookup(logic func, logic [POS_W-1:0] px,
			logic [POS_W-1:0] py, color_t color);
		pixel_result_t res;
		int            cx, cy, nx, ny, idx, walk_len, best;
		int unsigned   dx, dy, d, best_d;
		site_t         s;
		res = '0;
		cx = int'(px) / CHUNK_SIDE;
		cy = int'(py) / CHUNK_SIDE;
		if (func == FUNC_ADD) begin
			for (ny = cy - 1; ny <= cy + 1; ny++) begin
				for (nx = cx - 1; nx <= cx + 1; nx++) begin
					if (ny < 0 || ny >= CHUNKS_DOWN || nx < 0 || nx >= CHUNKS_ACROSS)
						continue;
					idx = ny * CHUNKS_ACROSS + nx;
					if (fill_count[idx] >= SITES_PER_CHUNK) begin
						res.status = STATUS_DROP;
						continue;
					end
					site_list[idx][fill_count[idx]] = '{color: color, y: py, x: px};
					fill_count[idx] = fill_count[idx] + 1'b1;
				end
			end
			return res;
		end
		if (cx >= CHUNKS_ACROSS || cy >= CHUNKS_DOWN) begin
			res.status = STATUS_EMPTY;
			return res;
		end
		idx = cy * CHUNKS_ACROSS + cx;
		walk_len = int'(fill_count[idx]);
		if (walk_len == 0) begin
			res.status = STATUS_EMPTY;
			return res;
		end
		best = 0;
		best_d = '1;
		// Strict less-than keeps the earliest listed site on a tie.
		for (int i = 0; i < walk_len; i++) begin
			s = site_list[idx][i];
			dx = (px > s.x) ? px - s.x : s.x - px;
			dy = (py > s.y) ? py - s.y : s.y - py;
			d = (dist_mode == MODE_MANHATTAN) ? dx + dy : dx * dx + dy * dy;
			if (d < best_d) begin
				best_d = d;
				best = i;
			end
		end
		s = site_list[idx][best];
		res.r = s.color.r;
		res.g = s.color.g;
		res.b = s.color.b;
		res.status = STATUS_OK;
		return res;
	endfunction

	// Input driver: holds an item until it is taken, then idles for its gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !s_fire) begin
			s_tvalid <= 1'b1;
		end else if (send_gap != 0) begin
			s_tvalid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (item_backlog.size() != 0) begin
			lookup_item_t it;
			it = item_backlog.pop_front();
			s_tdata <= {6'd0, it.color.b, it.color.g, it.color.r, it.y, it.x};
			s_tuser <= it.func;
			s_tvalid <= 1'b1;
			send_gap <= pick_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Result side back-pressure.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 99) < 30)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin : sample
		pixel_result_t want;
		s_fire <= s_tvalid && s_tready;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == REG_DISTANCE_MODE)
				dist_mode <= pwdata[MODE_W-1:0];
			if (s_tvalid && s_tready)
				expected_pixels.push_back(predict_lookup(s_tuser, s_tdata[8:0],
					s_tdata[17:9], '{b: s_tdata[41:34], g: s_tdata[33:26], r: s_tdata[25:18]}));
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: rgb %h status %0d", m_tdata, m_tuser);
				end else begin
					want = expected_pixels.pop_front();
					if (m_tdata[7:0] !== want.r || m_tdata[15:8] !== want.g ||
							m_tdata[23:16] !== want.b || m_tuser !== want.status) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("result mismatch: expected r %h g %h b %h status %0d, got r %h g %h b %h status %0d",
								want.r, want.g, want.b, want.status,
								m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser);
					end
				end
			end
		end
	end

	task automatic push_item(logic func, int x, int y, int r, int g, int b);
		lookup_item_t it;
		it.func = func;
		it.x = POS_W'(x);
		it.y = POS_W'(y);
		it.color = '{b: COLOR_W'(b), g: COLOR_W'(g), r: COLOR_W'(r)};
		item_backlog.push_back(it);
	endtask

	// Most items land in a 3x3 block of chunks so that lists fill up and overflow;
	// the rest are unconstrained noise over the whole plane.
	task automatic queue_random(int count, int hot_cx, int hot_cy);
		int unsigned roll;
		lookup_item_t it;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			it.color = color_t'($urandom);
			if (roll < 15) begin
				it.func = 1'($urandom_range(0, 1));
				it.x = POS_W'($urandom);
				it.y = POS_W'($urandom);
			end else begin
				it.func = (roll < 58) ? FUNC_ADD : FUNC_QUERY;
				it.x = POS_W'((hot_cx + $urandom_range(0, 2)) * CHUNK_SIDE +
					$urandom_range(0, CHUNK_SIDE - 1));
				it.y = POS_W'((hot_cy + $urandom_range(0, 2)) * CHUNK_SIDE +
					$urandom_range(0, CHUNK_SIDE - 1));
			end
			item_backlog.push_back(it);
		end
	endtask

	task automatic write_reg(logic [APB_AW-1:0] addr, logic [MODE_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {30'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_idle();
		while (item_backlog.size() != 0 || s_tvalid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		foreach (fill_count[i])
			fill_count[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty chunk, with color bits set that a query must ignore.
		push_item(FUNC_QUERY, 256, 256, 255, 255, 255);
		// Sites at the four corners, where most neighbors fall off the grid.
		push_item(FUNC_ADD, 0, 0, 255, 255, 255);
		push_item(FUNC_ADD, 511, 511, 0, 0, 0);
		push_item(FUNC_ADD, 0, 511, 255, 0, 170);
		push_item(FUNC_ADD, 511, 0, 85, 255, 0);
		push_item(FUNC_QUERY, 0, 0, 0, 0, 0);
		push_item(FUNC_QUERY, 511, 511, 255, 255, 255);
		push_item(FUNC_QUERY, 511, 0, 0, 0, 0);
		push_item(FUNC_QUERY, 0, 511, 0, 0, 0);
		push_item(FUNC_QUERY, 31, 31, 0, 0, 0);
		// Two sites at equal distance: the first one added must win.
		push_item(FUNC_ADD, 196, 200, 1, 2, 3);
		push_item(FUNC_ADD, 204, 200, 4, 5, 6);
		push_item(FUNC_QUERY, 200, 200, 0, 0, 0);
		// Nearest under squared Euclidean is not nearest under Manhattan here.
		push_item(FUNC_ADD, 106, 100, 10, 20, 30);
		push_item(FUNC_ADD, 104, 104, 40, 50, 60);
		push_item(FUNC_QUERY, 100, 100, 0, 0, 0);
		wait_idle();

		write_reg(REG_DISTANCE_MODE, MODE_MANHATTAN);
		push_item(FUNC_QUERY, 100, 100, 0, 0, 0);
		calm = ($urandom_range(0, 3) == 0);
		queue_random(170, 0, 0);
		wait_idle();

		write_reg(REG_DISTANCE_MODE, MODE_UNUSED_LO);
		calm = ($urandom_range(0, 3) == 0);
		queue_random(170, 13, 13);
		wait_idle();

		write_reg(REG_DISTANCE_MODE, MODE_UNUSED_HI);
		calm = 1'b1;
		queue_random(170, $urandom_range(0, 13), $urandom_range(0, 13));
		wait_idle();

		// A write to an address past the register list must leave the mode alone.
		write_reg(REG_DISTANCE_MODE, MODE_RESET);
		write_reg(REG_UNMAPPED, MODE_MANHATTAN);
		calm = 1'b0;
		queue_random(170, $urandom_range(0, 13), $urandom_range(0, 13));
		wait_idle();

		write_reg(REG_DISTANCE_MODE, MODE_MANHATTAN);
		calm = ($urandom_range(0, 3) == 0);
		queue_random(170, $urandom_range(0, 13), $urandom_range(0, 13));

		while (item_backlog.size() != 0 || s_tvalid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		mismatches += expected_pixels.size();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
rtl/core/cnsl_pkg.sv
rtl/core/cnsl_ctrl.sv
rtl/core/cnsl_datapath.sv
rtl/core/chunked_nearest_site_lookup.sv
dv/tb.sv
